@@ design/mqh_pkg.sv @@
// ----------------------------------------------------------------------------
// mqh_pkg
// Shared types, command codes and reset values of the message queue block.
// ----------------------------------------------------------------------------
package mqh_pkg;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_TICK    = 3'd1;
  localparam logic [2:0] CMD_RETIRE  = 3'd2;
  localparam logic [2:0] CMD_DISABLE = 3'd3;
  localparam logic [2:0] CMD_READ_Q  = 3'd4;
  localparam logic [2:0] CMD_READ_H  = 3'd5;

  localparam logic [2:0] CFG_MUTE_CHIME  = 3'd0;
  localparam logic [2:0] CFG_NORMAL_HOLD = 3'd1;
  localparam logic [2:0] CFG_BUSY_HOLD   = 3'd2;
  localparam logic [2:0] CFG_BUSY_COUNT  = 3'd3;

  localparam logic        RST_MUTE_CHIME  = 1'b0;
  localparam logic [15:0] RST_NORMAL_HOLD = 16'd320;
  localparam logic [15:0] RST_BUSY_HOLD   = 16'd256;
  localparam logic [4:0]  RST_BUSY_COUNT  = 5'd6;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  // One stored message, 78 bits.
  typedef struct packed {
    logic [7:0]  kind;
    logic [31:0] assoc;
    logic        disabled;
    logic [15:0] date_word;
    logic [4:0]  day;
    logic [15:0] ticks;
  } entry_t;

  typedef struct packed {
    logic        valid;
    entry_t      entry;
    logic        chime;
    logic        retired;
    logic [4:0]  pending_count;
    logic [6:0]  history_count;
  } result_t;

  function automatic logic [4:0] month_days(input logic [2:0] month);
    logic [4:0] d;
    case (month)
      3'd1, 3'd3, 3'd6: d = 5'd30;
      default:          d = 5'd31;
    endcase
    return d;
  endfunction

  // Day of month from the fractional progress through the month.
  function automatic logic [4:0] day_stamp(input logic [15:0] my, input logic [15:0] mt);
    logic [20:0] prod;
    prod = 21'(month_days(my[2:0])) * 21'(mt);
    return prod[20:16] + 5'd1;
  endfunction

endpackage

@@ design/mqh_out_stage.sv @@
// ----------------------------------------------------------------------------
// mqh_out_stage
// Result register: holds one item until the downstream side takes it.
// ----------------------------------------------------------------------------
module mqh_out_stage
  import mqh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    stall_i,
  output logic    free_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ design/message_queue_with_history.sv @@
// ----------------------------------------------------------------------------
// message_queue_with_history
// Pending message queue with a history ring, both held in synchronous RAMs.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_stall_o is low only while the block is
// idle. An add on a full queue first retires the head; reads, other commands
// and the no-op cases (tick or retire on an empty queue, add of kind zero)
// go straight to the report; disable sweeps the queue and then the history,
// one RAM read per swept entry. Every step ends with a RAM read of the
// reported entry; the result then sits in an output register while the next
// item is accepted.
module message_queue_with_history
  import mqh_pkg::*;
#(
  parameter int QUEUE_SLOTS   = 16,
  parameter int HISTORY_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  item_type_i,
  input  logic [31:0] item_assoc_i,
  input  logic [15:0] date_word_i,
  input  logic [15:0] month_ticks_i,
  input  logic [5:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        entry_valid_o,
  output logic [7:0]  entry_type_o,
  output logic [31:0] entry_assoc_o,
  output logic        entry_disabled_o,
  output logic [15:0] entry_date_word_o,
  output logic [4:0]  entry_day_o,
  output logic [15:0] entry_ticks_o,
  output logic        chime_o,
  output logic        retired_o,
  output logic [4:0]  pending_count_o,
  output logic [6:0]  history_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int QW  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int QCW = $clog2(QUEUE_SLOTS + 1);
  localparam int HW  = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
  localparam int HCW = $clog2(HISTORY_SLOTS + 1);
  localparam int CW  = (QCW > HCW) ? QCW : HCW;
  localparam int QAW = ((QW > 6) ? QW : 6) + 1;
  localparam int HAW = ((HW > 6) ? HW : 6) + 1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_RET_RD   = 10'b0000000010,
    S_RET_WR   = 10'b0000000100,
    S_ADD_WR   = 10'b0000001000,
    S_TICK_RD  = 10'b0000010000,
    S_TICK_WR  = 10'b0000100000,
    S_DIS_Q    = 10'b0001000000,
    S_DIS_H    = 10'b0010000000,
    S_REP      = 10'b0100000000,
    S_REP_WAIT = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic        mute_q;
  logic [15:0] normal_hold_q, busy_hold_q;
  logic [4:0]  busy_count_q;

  // latched item
  logic [2:0]  cmd_q;
  logic [7:0]  kind_q;
  logic [31:0] assoc_q;
  logic [15:0] my_q, mt_q;
  logic [5:0]  idx_q;

  // queue and history pointers
  logic [QW-1:0]  qhead_q, qhead_d;
  logic [QCW-1:0] qfill_q, qfill_d;
  logic [HW-1:0]  hold_q, hold_d;
  logic [HCW-1:0] hfill_q, hfill_d;

  logic chime_q, chime_d, retired_q, retired_d;
  logic rep_ok_q, rep_ok_d, rep_hist_q, rep_hist_d;
  logic pend_q, pend_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [QW-1:0] swq_q, swq_d;
  logic [HW-1:0] swh_q, swh_d;

  // RAMs
  entry_t q_mem [QUEUE_SLOTS];
  entry_t h_mem [HISTORY_SLOTS];
  entry_t q_rdata_q, h_rdata_q, q_wdata, h_wdata;
  logic [QW-1:0] q_raddr, q_raddr_q, q_waddr;
  logic [HW-1:0] h_raddr, h_raddr_q, h_waddr;
  logic q_we, h_we;

  logic in_acc, do_retire, load_out, out_free;
  result_t res, res_out;

  // ---------------------------------------------------------------------------
  // address arithmetic
  logic [QW-1:0] qhead_inc, swq_inc, qtail, qslot;
  logic [HW-1:0] hold_inc, swh_inc, hpos, hslot;
  logic [QW:0]   tsum;
  logic [HW:0]   psum;
  logic [QAW-1:0] qsum;
  logic [HAW-1:0] hsum;
  logic q_full, h_full;

  assign q_full    = (qfill_q == QCW'(QUEUE_SLOTS));
  assign h_full    = (hfill_q == HCW'(HISTORY_SLOTS));
  assign qhead_inc = (qhead_q == QW'(QUEUE_SLOTS - 1)) ? '0 : qhead_q + 1'b1;
  assign swq_inc   = (swq_q == QW'(QUEUE_SLOTS - 1)) ? '0 : swq_q + 1'b1;
  assign hold_inc  = (hold_q == HW'(HISTORY_SLOTS - 1)) ? '0 : hold_q + 1'b1;
  assign swh_inc   = (swh_q == HW'(HISTORY_SLOTS - 1)) ? '0 : swh_q + 1'b1;

  always_comb begin
    logic [QW:0]    tw;
    logic [HW:0]    pw;
    logic [QAW-1:0] qw;
    logic [HAW-1:0] hw;
    tsum = (QW+1)'(qhead_q) + (QW+1)'(qfill_q);
    tw   = (tsum >= (QW+1)'(QUEUE_SLOTS)) ? tsum - (QW+1)'(QUEUE_SLOTS) : tsum;
    qtail = tw[QW-1:0];
    psum = (HW+1)'(hold_q) + (HW+1)'(hfill_q);
    pw   = (psum >= (HW+1)'(HISTORY_SLOTS)) ? psum - (HW+1)'(HISTORY_SLOTS) : psum;
    hpos = h_full ? hold_q : pw[HW-1:0];
    qsum = QAW'(qhead_q) + QAW'(idx_q);
    qw   = (qsum >= QAW'(QUEUE_SLOTS)) ? qsum - QAW'(QUEUE_SLOTS) : qsum;
    qslot = qw[QW-1:0];
    hsum = HAW'(hold_q) + HAW'(idx_q);
    hw   = (hsum >= HAW'(HISTORY_SLOTS)) ? hsum - HAW'(HISTORY_SLOTS) : hsum;
    hslot = hw[HW-1:0];
  end

  // ---------------------------------------------------------------------------
  // sequencer
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    entry_t     mod;
    logic [15:0] tk_new, hold;
    logic       q_ok, h_ok;
    state_d    = state_q;
    qhead_d    = qhead_q;
    qfill_d    = qfill_q;
    hold_d     = hold_q;
    hfill_d    = hfill_q;
    chime_d    = chime_q;
    retired_d  = retired_q;
    rep_ok_d   = rep_ok_q;
    rep_hist_d = rep_hist_q;
    pend_d     = 1'b0;
    cnt_d      = cnt_q;
    swq_d      = swq_q;
    swh_d      = swh_q;
    q_raddr    = q_raddr_q;
    h_raddr    = h_raddr_q;
    q_we       = 1'b0;
    q_waddr    = qhead_q;
    q_wdata    = q_rdata_q;
    h_we       = 1'b0;
    h_wdata    = q_rdata_q;
    do_retire  = 1'b0;
    load_out   = 1'b0;
    mod        = q_rdata_q;
    tk_new     = q_rdata_q.ticks;
    hold       = normal_hold_q;
    q_ok       = 7'(idx_q) < 7'(qfill_q);
    h_ok       = 11'(idx_q) < 11'(hfill_q);

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          chime_d   = 1'b0;
          retired_d = 1'b0;
          case (cmd_i)
            CMD_ADD: begin
              if (item_type_i == 8'd0) begin
                state_d = S_REP;
              end else if (q_full) begin
                state_d = S_RET_RD;
              end else begin
                state_d = S_ADD_WR;
              end
            end
            CMD_TICK:    state_d = (qfill_q == '0) ? S_REP : S_TICK_RD;
            CMD_RETIRE:  state_d = (qfill_q == '0) ? S_REP : S_RET_RD;
            CMD_DISABLE: begin
              state_d = S_DIS_Q;
              cnt_d   = '0;
              swq_d   = qhead_q;
            end
            default:     state_d = S_REP;
          endcase
        end
      end
      S_RET_RD: begin
        q_raddr = qhead_q;
        state_d = S_RET_WR;
      end
      S_RET_WR: begin
        do_retire = 1'b1;
        state_d   = (cmd_q == CMD_ADD) ? S_ADD_WR : S_REP;
      end
      S_ADD_WR: begin
        q_we    = 1'b1;
        q_waddr = qtail;
        q_wdata = '{kind: kind_q, assoc: assoc_q, disabled: 1'b0, date_word: my_q,
                    day: day_stamp(my_q, mt_q), ticks: 16'd0};
        qfill_d = qfill_q + 1'b1;
        state_d = S_REP;
      end
      S_TICK_RD: begin
        q_raddr = qhead_q;
        state_d = S_TICK_WR;
      end
      S_TICK_WR: begin
        // saturate the shown-ticks count
        if (q_rdata_q.ticks != TICKS_MAX) begin
          tk_new = q_rdata_q.ticks + 16'd1;
        end
        mod.ticks = tk_new;
        q_we    = 1'b1;
        q_wdata = mod;
        h_wdata = mod;
        chime_d = (q_rdata_q.ticks == 16'd1) && !mute_q;
        if (7'(qfill_q) >= 7'(busy_count_q)) begin
          hold = busy_hold_q;
        end
        do_retire = (tk_new >= hold);
        state_d   = S_REP;
      end
      S_DIS_Q: begin
        if (pend_q && q_rdata_q.kind == kind_q && q_rdata_q.assoc == assoc_q) begin
          q_we     = 1'b1;
          q_waddr  = q_raddr_q;
          mod.disabled = 1'b1;
          q_wdata  = mod;
        end
        if (cnt_q < CW'(qfill_q)) begin
          q_raddr = swq_q;
          pend_d  = 1'b1;
          swq_d   = swq_inc;
          cnt_d   = cnt_q + 1'b1;
        end else begin
          state_d = S_DIS_H;
          cnt_d   = '0;
          swh_d   = hold_q;
        end
      end
      S_DIS_H: begin
        if (pend_q && h_rdata_q.kind == kind_q && h_rdata_q.assoc == assoc_q) begin
          h_we    = 1'b1;
          h_wdata = h_rdata_q;
          h_wdata.disabled = 1'b1;
        end
        if (cnt_q < CW'(hfill_q)) begin
          h_raddr = swh_q;
          pend_d  = 1'b1;
          swh_d   = swh_inc;
          cnt_d   = cnt_q + 1'b1;
        end else begin
          state_d = S_REP;
        end
      end
      S_REP: begin
        rep_hist_d = 1'b0;
        if (cmd_q == CMD_READ_Q) begin
          rep_ok_d = q_ok;
          q_raddr  = q_ok ? qslot : qhead_q;
        end else if (cmd_q == CMD_READ_H) begin
          rep_ok_d   = h_ok;
          rep_hist_d = 1'b1;
          h_raddr    = h_ok ? hslot : hold_q;
        end else begin
          rep_ok_d = (qfill_q != '0);
          q_raddr  = qhead_q;
        end
        state_d = S_REP_WAIT;
      end
      S_REP_WAIT: begin
        // read addresses hold, so the RAM data stays put until the slot frees
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // move the head to history; drop the oldest entry when history is full
    if (do_retire) begin
      h_we      = 1'b1;
      retired_d = 1'b1;
      qhead_d   = qhead_inc;
      qfill_d   = qfill_q - 1'b1;
      if (h_full) begin
        hold_d = hold_inc;
      end else begin
        hfill_d = hfill_q + 1'b1;
      end
    end
  end

  assign h_waddr = (state_q == S_DIS_H) ? h_raddr_q : hpos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mute_q        <= RST_MUTE_CHIME;
      normal_hold_q <= RST_NORMAL_HOLD;
      busy_hold_q   <= RST_BUSY_HOLD;
      busy_count_q  <= RST_BUSY_COUNT;
      cmd_q         <= CMD_ADD;
      qhead_q       <= '0;
      qfill_q       <= '0;
      hold_q        <= '0;
      hfill_q       <= '0;
      chime_q       <= 1'b0;
      retired_q     <= 1'b0;
      rep_ok_q      <= 1'b0;
      rep_hist_q    <= 1'b0;
      pend_q        <= 1'b0;
      cnt_q         <= '0;
      swq_q         <= '0;
      swh_q         <= '0;
    end else begin
      state_q    <= state_d;
      qhead_q    <= qhead_d;
      qfill_q    <= qfill_d;
      hold_q     <= hold_d;
      hfill_q    <= hfill_d;
      chime_q    <= chime_d;
      retired_q  <= retired_d;
      rep_ok_q   <= rep_ok_d;
      rep_hist_q <= rep_hist_d;
      pend_q     <= pend_d;
      cnt_q      <= cnt_d;
      swq_q      <= swq_d;
      swh_q      <= swh_d;
      if (in_acc) begin
        cmd_q <= cmd_i;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MUTE_CHIME:  mute_q        <= cfg_data_i[0];
          CFG_NORMAL_HOLD: normal_hold_q <= cfg_data_i;
          CFG_BUSY_HOLD:   busy_hold_q   <= cfg_data_i;
          CFG_BUSY_COUNT:  busy_count_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= item_type_i;
      assoc_q <= item_assoc_i;
      my_q    <= date_word_i;
      mt_q    <= month_ticks_i;
      idx_q   <= slot_index_i;
    end
    q_raddr_q <= q_raddr;
    h_raddr_q <= h_raddr;
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= q_mem[q_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_mem[h_waddr] <= h_wdata;
    end
    h_rdata_q <= h_mem[h_raddr];
  end

  // ---------------------------------------------------------------------------
  // result
  always_comb begin
    res.valid         = rep_ok_q;
    res.entry         = '0;
    if (rep_ok_q) begin
      res.entry = rep_hist_q ? h_rdata_q : q_rdata_q;
    end
    res.chime         = chime_q;
    res.retired       = retired_q;
    res.pending_count = 5'(qfill_q);
    res.history_count = 7'(hfill_q);
  end

  mqh_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load_out),
    .res_i   (res),
    .stall_i (out_stall_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .res_o   (res_out)
  );

  assign entry_valid_o      = res_out.valid;
  assign entry_type_o       = res_out.entry.kind;
  assign entry_assoc_o      = res_out.entry.assoc;
  assign entry_disabled_o   = res_out.entry.disabled;
  assign entry_date_word_o  = res_out.entry.date_word;
  assign entry_day_o        = res_out.entry.day;
  assign entry_ticks_o      = res_out.entry.ticks;
  assign chime_o            = res_out.chime;
  assign retired_o          = res_out.retired;
  assign pending_count_o    = res_out.pending_count;
  assign history_count_o    = res_out.history_count;

  // ---------------------------------------------------------------------------
  // assertions
  a_qfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qfill_q <= QCW'(QUEUE_SLOTS))
    else $error("queue fill beyond capacity");

  a_hfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hfill_q <= HCW'(HISTORY_SLOTS))
    else $error("history fill beyond capacity");

  a_pend_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_DIS_Q || state_q == S_DIS_H))
    else $error("sweep read outstanding outside a sweep");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result loaded over a waiting item");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for message_queue_with_history: directed and random
// items against a local model of the queue and history ring, with stalls.
// ----------------------------------------------------------------------------
module tb;
  import mqh_pkg::*;

  localparam int QSLOTS = 16;
  localparam int HSLOTS = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [2:0] CMD_NOP6 = 3'd6;
  localparam logic [2:0] CMD_NOP7 = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = CMD_ADD;
  logic [7:0]  item_type_i = '0;
  logic [31:0] item_assoc_i = '0;
  logic [15:0] date_word_i = '0;
  logic [15:0] month_ticks_i = '0;
  logic [5:0]  slot_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        entry_valid_o;
  logic [7:0]  entry_type_o;
  logic [31:0] entry_assoc_o;
  logic        entry_disabled_o;
  logic [15:0] entry_date_word_o;
  logic [4:0]  entry_day_o;
  logic [15:0] entry_ticks_o;
  logic        chime_o;
  logic        retired_o;
  logic [4:0]  pending_count_o;
  logic [6:0]  history_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CFG_MUTE_CHIME;
  logic [15:0] cfg_data_i = '0;

  message_queue_with_history DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // local copy of the block state
  entry_t      pend_q [QSLOTS];
  entry_t      hist_q [HSLOTS];
  int unsigned pend_head, pend_fill, hist_old, hist_fill;
  logic        mute_r;
  logic [15:0] normal_hold_r, busy_hold_r;
  logic [4:0]  busy_count_r;

  result_t     expected_results[$];
  int          fail_count = 0;
  int          items_sent = 0, chimes_seen = 0, retires_seen = 0;
  int          burst_left = 0;
  bit          hold_off = 1'b0;
  int          idle_cycles = 0;

  function automatic logic [4:0] month_len(input logic [2:0] m);
    logic [4:0] lens [8];
    lens = '{5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31};
    return lens[m];
  endfunction

  function automatic bit move_head_to_history();
    int unsigned pos;
    if (pend_fill == 0) return 1'b0;
    if (hist_fill < HSLOTS) begin
      pos = (hist_old + hist_fill) % HSLOTS;
      hist_fill++;
    end else begin
      pos = hist_old;
      hist_old = (hist_old + 1) % HSLOTS;
    end
    hist_q[pos] = pend_q[pend_head];
    pend_head = (pend_head + 1) % QSLOTS;
    pend_fill--;
    return 1'b1;
  endfunction

  function automatic result_t predict_step(input logic [2:0] cmd, input logic [7:0] kind,
                                           input logic [31:0] assoc, input logic [15:0] my,
                                           input logic [15:0] mt, input logic [5:0] idx);
    result_t     r;
    entry_t      e;
    int unsigned hold, slot;
    logic [15:0] old;
    bit          have;
    r = '0;
    have = 1'b0;
    case (cmd)
      CMD_ADD: if (kind != 8'd0) begin
        if (pend_fill >= QSLOTS) r.retired = move_head_to_history();
        e = '0;
        e.kind = kind;
        e.assoc = assoc;
        e.date_word = my;
        e.day = 5'(((32'(month_len(my[2:0])) * 32'(mt)) >> 16) + 1);
        pend_q[(pend_head + pend_fill) % QSLOTS] = e;
        pend_fill++;
      end
      CMD_TICK: if (pend_fill != 0) begin
        old = pend_q[pend_head].ticks;
        if (old != TICKS_MAX) pend_q[pend_head].ticks = old + 16'd1;
        r.chime = (old == 16'd1) && !mute_r;
        hold = (pend_fill >= busy_count_r) ? busy_hold_r : normal_hold_r;
        if (pend_q[pend_head].ticks >= hold) r.retired = move_head_to_history();
      end
      CMD_RETIRE: r.retired = move_head_to_history();
      CMD_DISABLE: begin
        for (int i = 0; i < pend_fill; i++) begin
          slot = (pend_head + i) % QSLOTS;
          if (pend_q[slot].kind == kind && pend_q[slot].assoc == assoc)
            pend_q[slot].disabled = 1'b1;
        end
        for (int i = 0; i < hist_fill; i++) begin
          slot = (hist_old + i) % HSLOTS;
          if (hist_q[slot].kind == kind && hist_q[slot].assoc == assoc)
            hist_q[slot].disabled = 1'b1;
        end
      end
      default: ;
    endcase
    if (cmd == CMD_READ_Q) begin
      have = idx < pend_fill;
      if (have) e = pend_q[(pend_head + idx) % QSLOTS];
    end else if (cmd == CMD_READ_H) begin
      have = idx < hist_fill;
      if (have) e = hist_q[(hist_old + idx) % HSLOTS];
    end else begin
      have = pend_fill != 0;
      if (have) e = pend_q[pend_head];
    end
    r.valid = have;
    r.entry = have ? e : '0;
    r.pending_count = 5'(pend_fill);
    r.history_count = 7'(hist_fill);
    return r;
  endfunction

  // Drive one item, hold it until accepted, then maybe open a gap.
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] kind,
                           input logic [31:0] assoc, input logic [15:0] my,
                           input logic [15:0] mt, input logic [5:0] idx);
    int gap;
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    item_type_i   <= kind;
    item_assoc_i  <= assoc;
    date_word_i   <= my;
    month_ticks_i <= mt;
    slot_index_i  <= idx;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_step(cmd, kind, assoc, my, mt, idx));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MUTE_CHIME:  mute_r = data[0];
      CFG_NORMAL_HOLD: normal_hold_r = data;
      CFG_BUSY_HOLD:   busy_hold_r = data;
      CFG_BUSY_COUNT:  busy_count_r = data[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic mute, input logic [15:0] nh, input logic [15:0] bh,
                           input logic [4:0] bc);
    drain();
    write_reg(CFG_MUTE_CHIME, {15'd0, mute});
    write_reg(CFG_NORMAL_HOLD, nh);
    write_reg(CFG_BUSY_HOLD, bh);
    write_reg(CFG_BUSY_COUNT, {11'd0, bc});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_empty_block();
    send_item(CMD_TICK, 8'd1, '0, '0, '0, '0);
    send_item(CMD_RETIRE, 8'd1, '0, '0, '0, '0);
    send_item(CMD_READ_Q, 8'd0, '0, '0, '0, 6'd0);
    send_item(CMD_READ_H, 8'd0, '0, '0, '0, 6'd63);
    send_item(CMD_ADD, 8'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, '0);
    send_item(CMD_NOP6, 8'd0, '0, '0, '0, '0);
  endtask

  task automatic test_add_extremes();
    send_item(CMD_ADD, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 6'd63);
    send_item(CMD_ADD, 8'd1, 32'd0, 16'h0001, 16'd0, 6'd0);
    send_item(CMD_ADD, 8'd7, 32'h8000_0001, 16'hFFFE, 16'h8000, 6'd0);
    send_item(CMD_READ_Q, 8'd0, '0, '0, '0, 6'd2);
    send_item(CMD_READ_Q, 8'd0, '0, '0, '0, 6'd3);
    send_item(CMD_NOP7, 8'd0, '0, '0, '0, '0);
  endtask

  // default hold 320 keeps the head; second tick chimes
  task automatic test_chime_and_retire();
    repeat (3) send_item(CMD_TICK, 8'd0, '0, '0, '0, '0);
    send_item(CMD_RETIRE, 8'd0, '0, '0, '0, '0);
    send_item(CMD_READ_H, 8'd0, '0, '0, '0, 6'd0);
  endtask

  task automatic test_disable();
    send_item(CMD_DISABLE, 8'd255, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(CMD_DISABLE, 8'd7, 32'h8000_0001, '0, '0, '0);
    send_item(CMD_READ_H, 8'd0, '0, '0, '0, 6'd0);
    send_item(CMD_READ_Q, 8'd0, '0, '0, '0, 6'd1);
  endtask

  // overfill the queue so the head retires on add
  task automatic test_full_queue();
    for (int i = 0; i < QSLOTS; i++)
      send_item(CMD_ADD, 8'(i + 2), $urandom, 16'(i), 16'($urandom), '0);
  endtask

  task automatic test_hold_extremes();
    configure(1'b0, 16'd1, 16'd1, 5'd0);
    repeat (3) send_item(CMD_TICK, '0, '0, '0, '0, '0);
    configure(1'b1, 16'd65535, 16'd65535, 5'd16);
    repeat (3) send_item(CMD_TICK, '0, '0, '0, '0, '0);
  endtask

  // receiver holds off while items keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (20) send_item(CMD_READ_H, '0, '0, '0, '0, 6'($urandom));
  endtask

  task automatic random_items(input int count);
    logic [2:0]  cmd;
    logic [7:0]  kind;
    logic [31:0] assoc;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = CMD_ADD;
      else if (pick < 65) cmd = CMD_TICK;
      else if (pick < 70) cmd = CMD_RETIRE;
      else if (pick < 78) cmd = CMD_DISABLE;
      else if (pick < 88) cmd = CMD_READ_Q;
      else if (pick < 98) cmd = CMD_READ_H;
      else cmd = $urandom_range(0, 1) ? CMD_NOP6 : CMD_NOP7;
      // small pools make disable hit real entries
      kind = $urandom_range(0, 3) != 0 ? 8'($urandom_range(0, 3)) : 8'($urandom);
      assoc = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom;
      send_item(cmd, kind, assoc, 16'($urandom), 16'($urandom),
                $urandom_range(0, 1) ? 6'($urandom_range(0, 20)) : 6'($urandom));
    end
  endtask

  initial begin
    mute_r = RST_MUTE_CHIME;
    normal_hold_r = RST_NORMAL_HOLD;
    busy_hold_r = RST_BUSY_HOLD;
    busy_count_r = RST_BUSY_COUNT;
    pend_head = 0; pend_fill = 0; hist_old = 0; hist_fill = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_block();
    test_add_extremes();
    test_chime_and_retire();
    test_disable();
    test_full_queue();
    test_backpressure();
    test_hold_extremes();
    configure(1'b0, 16'd3, 16'd2, 5'd6);
    random_items(250);
    configure(1'b1, 16'd1, 16'd1, 5'd1);
    random_items(150);
    configure(1'b0, 16'd65535, 16'd65535, 5'd16);
    random_items(150);
    configure(1'b0, 16'd5, 16'd2, 5'd0);
    random_items(140);
    drain();
    $display("Sent %0d items over seven register settings; saw %0d chimes, %0d retires.",
             items_sent, chimes_seen, retires_seen);
    if (fail_count == 0)
      $display("message_queue_with_history regression: pass");
    else
      $display("message_queue_with_history regression: fail");
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        phase = (phase + 1) % 400;
        out_stall_i <= (phase < 150) ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (chime_o) chimes_seen++;
        if (retired_o) retires_seen++;
        if (entry_valid_o !== exp_r.valid) begin
          $error("entry_valid exp %0h got %0h", exp_r.valid, entry_valid_o); fail_count++;
        end
        if (entry_type_o !== exp_r.entry.kind) begin
          $error("entry_type exp %0h got %0h", exp_r.entry.kind, entry_type_o); fail_count++;
        end
        if (entry_assoc_o !== exp_r.entry.assoc) begin
          $error("entry_assoc exp %0h got %0h", exp_r.entry.assoc, entry_assoc_o);
          fail_count++;
        end
        if (entry_disabled_o !== exp_r.entry.disabled) begin
          $error("entry_disabled exp %0h got %0h", exp_r.entry.disabled, entry_disabled_o);
          fail_count++;
        end
        if (entry_date_word_o !== exp_r.entry.date_word) begin
          $error("entry_date_word exp %0h got %0h", exp_r.entry.date_word,
                 entry_date_word_o);
          fail_count++;
        end
        if (entry_day_o !== exp_r.entry.day) begin
          $error("entry_day exp %0d got %0d", exp_r.entry.day, entry_day_o); fail_count++;
        end
        if (entry_ticks_o !== exp_r.entry.ticks) begin
          $error("entry_ticks exp %0d got %0d", exp_r.entry.ticks, entry_ticks_o);
          fail_count++;
        end
        if (chime_o !== exp_r.chime) begin
          $error("chime exp %0h got %0h", exp_r.chime, chime_o); fail_count++;
        end
        if (retired_o !== exp_r.retired) begin
          $error("retired exp %0h got %0h", exp_r.retired, retired_o); fail_count++;
        end
        if (pending_count_o !== exp_r.pending_count) begin
          $error("pending_count exp %0d got %0d", exp_r.pending_count, pending_count_o);
          fail_count++;
        end
        if (history_count_o !== exp_r.history_count) begin
          $error("history_count exp %0d got %0d", exp_r.history_count, history_count_o);
          fail_count++;
        end
      end
    end
  end

  // count cycles in which no channel moves an item
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("message_queue_with_history regression: fail");
      $finish;
    end
  end

endmodule
